### src/cfv_pkg.sv
// cfv_pkg: shared types, constants and helpers for the circle fan vertex generator
// depends on nothing; used by every module in src but cfv_checker
`timescale 1ns / 1ps
`default_nettype none
package cfv_pkg;

  localparam int unsigned MaxSegments = 62;
  localparam int unsigned CordicIters = 20;
  localparam int unsigned IterW       = 5;
  localparam int unsigned CordicW     = 34;

  // cordic start value, gain compensation in q4.30
  localparam logic signed [CordicW-1:0] CordicGain = 34'sd652032874;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RECIP,
    ST_EMIT_CTR,
    ST_ROT_START,
    ST_ROT_RUN,
    ST_MUL_X,
    ST_SUM_X,
    ST_MUL_Y,
    ST_SUM_Y,
    ST_HOLD
  } seq_state_e;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [IterW-1:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### src/cfv_recip.sv
// cfv_recip: bit-serial restoring divider giving 2^32 / n and 2^32 mod n
// depends on cfv_pkg (style only)
`timescale 1ns / 1ps
`default_nettype none
module cfv_recip (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [5:0]  divisor_i,
  output logic             done_o,
  output logic [31:0]      quot_o,
  output logic [5:0]       rem_o
);
  import cfv_pkg::*;

  logic        busy_q, done_q;
  logic [5:0]  cnt_q, rem_q;
  logic [31:0] quot_q;
  logic [6:0]  trial, diff;
  logic        ge;

  // dividend is 2^32: only its top bit, shifted in first, is set
  assign trial = {rem_q, (cnt_q == 6'd0)};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[5:0] : trial[5:0];
      quot_q <= {quot_q[30:0], ge};
      cnt_q  <= cnt_q + 6'd1;
      if (cnt_q == 6'd32) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;
endmodule
`default_nettype wire

### src/cfv_cordic.sv
// cfv_cordic: iterative rotation-mode cordic, one micro-rotation per cycle
// depends on cfv_pkg for the arctangent table and gain
`timescale 1ns / 1ps
`default_nettype none
module cfv_cordic (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [31:0]        angle_i,
  output logic                    done_o,
  output logic signed [31:0]      cos_o,
  output logic signed [31:0]      sin_o
);
  import cfv_pkg::*;

  logic                      busy_q, done_q;
  logic [IterW-1:0]          iter_q;
  logic [1:0]                quad_q;
  logic signed [CordicW-1:0] x_q, y_q, z_q;
  logic signed [CordicW-1:0] dx, dy, at;
  logic [31:0]               rnd, z0;

  assign rnd = angle_i + 32'h2000_0000;
  assign z0  = angle_i - {rnd[31:30], 30'd0};
  assign dx  = y_q >>> iter_q;
  assign dy  = x_q >>> iter_q;
  assign at  = signed'({2'b00, atan_turns(iter_q)});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
      quad_q <= '0;
      x_q    <= '0;
      y_q    <= '0;
      z_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      iter_q <= '0;
      quad_q <= rnd[31:30];
      x_q    <= CordicGain;
      y_q    <= '0;
      z_q    <= signed'({{(CordicW-32){z0[31]}}, z0});
    end else if (busy_q) begin
      if (!z_q[CordicW-1]) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + at;
      end
      iter_q <= iter_q + IterW'(1);
      if (iter_q == IterW'(CordicIters - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // quadrant rotation is exact
  always_comb begin
    unique case (quad_q)
      2'd0: begin cos_o = x_q[31:0];     sin_o = y_q[31:0];     end
      2'd1: begin cos_o = -y_q[31:0];    sin_o = x_q[31:0];     end
      2'd2: begin cos_o = -x_q[31:0];    sin_o = -y_q[31:0];    end
      default: begin cos_o = y_q[31:0];  sin_o = -x_q[31:0];    end
    endcase
  end

  assign done_o = done_q;
endmodule
`default_nettype wire

### src/circle_fan_vertex_generator_unit.sv
// sequence: the divider computes the angle step, then the center vertex is emitted, then
// each rim vertex takes a cordic rotation and an x then a y multiply-add; HOLD waits for the sink
// a request of N segments yields the center vertex and N+1 rim vertices;
// the shared cordic rotator and the single multiplier serve the rim vertices one at a time
// one request in flight at a time; in_ready_o is high only while idle
// rst_ni clears the sequencer and valid flags asynchronously
`timescale 1ns / 1ps
`default_nettype none
module circle_fan_vertex_generator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] center_x_i,
  input  wire logic [31:0] center_y_i,
  input  wire logic [31:0] center_z_i,
  input  wire logic [30:0] radius_i,
  input  wire logic [5:0]  segments_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [5:0]       vertex_index_o,
  output logic [31:0]      pos_x_o,
  output logic [31:0]      pos_y_o,
  output logic [31:0]      pos_z_o,
  output logic             has_triangle_o,
  output logic [5:0]       tri_first_o,
  output logic [5:0]       tri_second_o,
  output logic             last_vertex_o
);
  import cfv_pkg::*;

  seq_state_e state_q, state_d;

  logic [31:0] cx_q, cy_q;
  logic [30:0] r_q;
  logic [5:0]  n_q, k_q;
  logic [31:0] ang_q;
  logic [6:0]  frac_q, frac_sum;
  logic [5:0]  n_clamp;

  logic        in_xfer, out_xfer;
  logic        recip_start, rot_start;
  logic        recip_done, rot_done;
  logic [31:0] step_quot;
  logic [5:0]  step_rem;
  logic signed [31:0] cos_v, sin_v, mul_b;
  logic signed [63:0] prod_q;
  logic signed [33:0] offs;
  logic signed [34:0] sum_x, sum_y;

  logic [5:0]  vidx_q;
  logic [31:0] px_q, py_q, pz_q;
  logic        tri_q, last_q, oval_q;
  logic [5:0]  tfa_q, tfb_q;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = oval_q && out_ready_i;

  always_comb begin
    if (segments_i == 6'd0) begin
      n_clamp = 6'd1;
    end else if (segments_i > 6'(MaxSegments)) begin
      n_clamp = 6'(MaxSegments);
    end else begin
      n_clamp = segments_i;
    end
  end

  cfv_recip u_recip (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (recip_start),
    .divisor_i (n_q),
    .done_o    (recip_done),
    .quot_o    (step_quot),
    .rem_o     (step_rem)
  );

  cfv_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rot_start),
    .angle_i (ang_q),
    .done_o  (rot_done),
    .cos_o   (cos_v),
    .sin_o   (sin_v)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:      if (in_valid_i) state_d = ST_RECIP;
      ST_RECIP:     if (recip_done) state_d = ST_EMIT_CTR;
      ST_EMIT_CTR:  state_d = ST_HOLD;
      ST_ROT_START: state_d = ST_ROT_RUN;
      ST_ROT_RUN:   if (rot_done) state_d = ST_MUL_X;
      ST_MUL_X:     state_d = ST_SUM_X;
      ST_SUM_X:     state_d = ST_MUL_Y;
      ST_MUL_Y:     state_d = ST_SUM_Y;
      ST_SUM_Y:     state_d = ST_HOLD;
      ST_HOLD: begin
        if (out_xfer) state_d = last_q ? ST_IDLE : ST_ROT_START;
      end
      default:      state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    recip_start = (state_q == ST_IDLE) && in_valid_i;
    rot_start   = (state_q == ST_ROT_START);
    mul_b       = (state_q == ST_MUL_Y) ? sin_v : cos_v;
  end

  assign frac_sum = frac_q + {1'b0, step_rem};
  assign offs     = 34'((prod_q + 64'sd536870912) >>> 30);
  assign sum_x    = signed'({{3{cx_q[31]}}, cx_q}) + 35'(offs);
  assign sum_y    = signed'({{3{cy_q[31]}}, cy_q}) + 35'(offs);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      oval_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_EMIT_CTR: begin
          oval_q <= 1'b1;
          k_q    <= '0;
        end
        ST_SUM_Y:    oval_q <= 1'b1;
        ST_HOLD: begin
          if (out_xfer) begin
            oval_q <= 1'b0;
            k_q    <= k_q + 6'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, payload registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cx_q <= center_x_i;
          cy_q <= center_y_i;
          pz_q <= center_z_i;
          r_q  <= radius_i;
          n_q  <= n_clamp;
        end
      end
      ST_EMIT_CTR: begin
        ang_q  <= '0;
        frac_q <= '0;
        vidx_q <= '0;
        px_q   <= cx_q;
        py_q   <= cy_q;
        tri_q  <= 1'b0;
        tfa_q  <= '0;
        tfb_q  <= '0;
        last_q <= 1'b0;
      end
      ST_ROT_START: begin
        // exact next angle: quotient and remainder of k*2^32 / n
        if (frac_sum >= {1'b0, n_q}) begin
          frac_q <= frac_sum - {1'b0, n_q};
          ang_q  <= ang_q + step_quot + 32'd1;
        end else begin
          frac_q <= frac_sum;
          ang_q  <= ang_q + step_quot;
        end
      end
      ST_MUL_X, ST_MUL_Y: prod_q <= signed'({1'b0, r_q}) * mul_b;
      ST_SUM_X: px_q <= sat32(sum_x);
      ST_SUM_Y: begin
        py_q   <= sat32(sum_y);
        vidx_q <= k_q;
        tri_q  <= (k_q <= n_q);
        tfa_q  <= (k_q <= n_q) ? k_q : 6'd0;
        tfb_q  <= (k_q <= n_q) ? k_q + 6'd1 : 6'd0;
        last_q <= (k_q == n_q + 6'd1);
      end
      default: ;
    endcase
  end

  assign out_valid_o    = oval_q;
  assign vertex_index_o = vidx_q;
  assign pos_x_o        = px_q;
  assign pos_y_o        = py_q;
  assign pos_z_o        = pz_q;
  assign has_triangle_o = tri_q;
  assign tri_first_o    = tfa_q;
  assign tri_second_o   = tfb_q;
  assign last_vertex_o  = last_q;
endmodule
`default_nettype wire

### src/cfv_checker.sv
// cfv_checker: port-level assertions for circle_fan_vertex_generator_unit
// depends on the top level's ports only; bound to it below
`timescale 1ns / 1ps
`default_nettype none
module cfv_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [31:0] center_x_i,
  input wire logic [31:0] center_y_i,
  input wire logic [31:0] center_z_i,
  input wire logic [30:0] radius_i,
  input wire logic [5:0]  segments_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [5:0]  vertex_index_o,
  input wire logic [31:0] pos_x_o,
  input wire logic [31:0] pos_y_o,
  input wire logic [31:0] pos_z_o,
  input wire logic        has_triangle_o,
  input wire logic [5:0]  tri_first_o,
  input wire logic [5:0]  tri_second_o,
  input wire logic        last_vertex_o
);

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while a vertex is pending");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(pos_x_o) && $stable(pos_y_o))
    else $error("stalled vertex changed");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_vertex_o |=> in_ready_o)
    else $error("not idle after last vertex");

  a_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && vertex_index_o == 6'd0 |-> !has_triangle_o && !last_vertex_o)
    else $error("center vertex flags wrong");

  a_fan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_triangle_o |->
      tri_first_o == vertex_index_o && tri_second_o == tri_first_o + 6'd1)
    else $error("fan triangle indices wrong");

endmodule

bind circle_fan_vertex_generator_unit cfv_checker u_cfv_checker (.*);
`default_nettype wire
